// File: rtl/core/ptrn_pkg.sv
// Shared types, widths and helpers for the perceptron trainer.
// Used by ptrn_cell, ptrn_mac and perceptron_trainer; depends on nothing.
package ptrn_pkg;

   localparam int FEATURE_W            = 16;
   localparam int WEIGHT_W             = 24;
   localparam int PROD_W               = WEIGHT_W + FEATURE_W;
   localparam int SCORE_W              = 48;
   localparam int CFG_W                = 7;
   localparam int LEN_MAX_W            = 11;   // holds a ring length up to 1024
   localparam int DEFAULT_MAX_FEATURES = 64;
   localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

   // One ring slot: weight and the feature buffered for it in the current row
   typedef struct packed {
      logic signed [WEIGHT_W-1:0]  weight;
      logic signed [FEATURE_W-1:0] feature;
   } pair_type;

   // Control broadcast to every cell of the ring
   typedef struct packed {
      logic                 shift;
      logic [LEN_MAX_W-1:0] len;
   } ring_ctrl_type;

   typedef enum logic [2:0] {
      ST_RUN,      // taking features
      ST_SUM,      // last product is being accumulated
      ST_EMIT,     // score final, waiting for the result slot
      ST_UPDATE,   // correcting weights, one per cycle
      ST_ALIGN     // rotating a partial row back to position zero
   } state_type;

   // Weight plus or minus feature, saturated to the weight range
   function automatic logic signed [WEIGHT_W-1:0] sat_update(
         input logic signed [WEIGHT_W-1:0]  weight,
         input logic signed [FEATURE_W-1:0] feature,
         input logic                        add);
      logic signed [WEIGHT_W:0] wide;
      logic signed [WEIGHT_W:0] fext;
      fext = (WEIGHT_W + 1)'(feature);
      wide = add ? (WEIGHT_W + 1)'(weight) + fext : (WEIGHT_W + 1)'(weight) - fext;
      if (wide[WEIGHT_W] != wide[WEIGHT_W-1]) begin
         sat_update = wide[WEIGHT_W] ? {1'b1, {(WEIGHT_W-1){1'b0}}}
                                     : {1'b0, {(WEIGHT_W-1){1'b1}}};
      end else begin
         sat_update = wide[WEIGHT_W-1:0];
      end
   endfunction

endpackage

// File: rtl/core/ptrn_cell.sv
// One slot of the weight ring: holds a weight and its buffered feature.
// Depends on ptrn_pkg for pair_type and ring_ctrl_type.
module ptrn_cell #(
   parameter int INDEX = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ptrn_pkg::ring_ctrl_type ctrl,
   input  ptrn_pkg::pair_type     next_pair,   // from the neighbor above
   input  ptrn_pkg::pair_type     wrap_pair,   // from the head, when this is the tail
   output ptrn_pkg::pair_type     pair
);
   import ptrn_pkg::*;

   logic                        active;
   logic                        is_tail;
   pair_type                    pair_in;
   logic signed [WEIGHT_W-1:0]  weight_ff;
   logic signed [FEATURE_W-1:0] feature_ff;

   // place of this cell relative to the current ring length
   assign active  = ctrl.len > LEN_MAX_W'(INDEX);
   assign is_tail = ctrl.len == LEN_MAX_W'(INDEX + 1);
   assign pair_in = is_tail ? wrap_pair : next_pair;

   // weights reset to zero
   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= '0;
      end else if (ctrl.shift && active) begin
         weight_ff <= pair_in.weight;
      end
   end

   // feature buffer, no reset
   always_ff @(posedge clock) begin
      if (ctrl.shift && active) begin
         feature_ff <= pair_in.feature;
      end
   end

   assign pair.weight  = weight_ff;
   assign pair.feature = feature_ff;

endmodule

// File: rtl/core/ptrn_mac.sv
// Multiply-accumulate unit: registered weight x feature, then saturating add.
// Depends on ptrn_pkg for widths.
module ptrn_mac (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       start,
   input  logic                                       clear,
   input  logic signed [ptrn_pkg::WEIGHT_W-1:0]       weight,
   input  logic signed [ptrn_pkg::FEATURE_W-1:0]      feature,
   output logic signed [ptrn_pkg::SCORE_W-1:0]        acc,
   output logic                                       busy
);
   import ptrn_pkg::*;

   logic signed [PROD_W-1:0]  prod_ff;
   logic                      prod_vld_ff;
   logic signed [SCORE_W-1:0] acc_ff;
   logic signed [SCORE_W-1:0] acc_in;
   logic signed [SCORE_W:0]   sum;

   // product stage
   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff <= weight * feature;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= start;
      end
   end

   // saturating accumulate
   always_comb begin
      sum    = (SCORE_W + 1)'(acc_ff) + (SCORE_W + 1)'(prod_ff);
      acc_in = acc_ff;
      if (clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         if (sum[SCORE_W] != sum[SCORE_W-1]) begin
            acc_in = sum[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}}
                                  : {1'b0, {(SCORE_W-1){1'b1}}};
         end else begin
            acc_in = sum[SCORE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   assign acc  = acc_ff;
   assign busy = prod_vld_ff;

endmodule

// File: rtl/core/perceptron_trainer.sv
// Perceptron trainer top level: weight ring, MAC unit, row sequencer, result register.
// Depends on ptrn_pkg, ptrn_cell and ptrn_mac.
//
//  channel | ports                                   | beat
//  --------+-----------------------------------------+-----------------------------
//  req     | req_valid req_stall req_feature/label/learn | one feature of a row
//  rsp     | rsp_valid rsp_stall rsp_prediction/updated/score | one result per row
//  csr     | csr_valid csr_ready csr_active_features | row length write
//
// A feature is taken every cycle inside a row; the weight for it sits at the head of
// the ring, which rotates one slot per feature. After the last feature the row passes
// through the final add (ST_SUM) and the result load (ST_EMIT), then through the update
// pass, one weight per slot of the row, when the weights are corrected.
// A length write in the middle of a row first rotates the ring back home (ST_ALIGN).
// Reset clears the weights in their flops. A stalled result holds only the row end;
// features keep flowing while a result waits.
module perceptron_trainer #(
   parameter int MAX_FEATURES = ptrn_pkg::DEFAULT_MAX_FEATURES
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // feature input
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [ptrn_pkg::FEATURE_W-1:0]  req_feature,
   input  logic                                   req_label,
   input  logic                                   req_learn,
   // result output
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_prediction,
   output logic                                   rsp_updated,
   output logic signed [ptrn_pkg::SCORE_W-1:0]    rsp_score,
   // configuration
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [ptrn_pkg::CFG_W-1:0]             csr_active_features
);
   import ptrn_pkg::*;

   localparam int LEN_W = $clog2(MAX_FEATURES + 1);
   localparam int CMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;

   // clamp a written row length to 1..MAX_FEATURES
   function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_W-1:0] raw);
      logic [CMP_W-1:0] wide;
      wide = CMP_W'(raw);
      if (wide == '0) begin
         eff_len = LEN_W'(1);
      end else if (wide > CMP_W'(MAX_FEATURES)) begin
         eff_len = LEN_W'(MAX_FEATURES);
      end else begin
         eff_len = LEN_W'(wide);
      end
   endfunction

   state_type                  state_ff, state_in;
   logic [LEN_W-1:0]           pos_ff, pos_in;
   logic [LEN_W-1:0]           len_ff, len_in;
   logic [CFG_W-1:0]           cfg_ff;
   logic                       label_ff;
   logic                       learn_ff;
   logic                       rsp_valid_ff;
   logic                       rsp_pred_ff;
   logic                       rsp_upd_ff;
   logic signed [SCORE_W-1:0]  rsp_score_ff;

   logic                       req_accept;
   logic                       csr_accept;
   logic                       rsp_load;
   logic                       mac_clear;
   logic                       mac_busy;
   logic signed [SCORE_W-1:0]  acc;
   logic                       pred;
   logic                       upd;
   logic                       at_end;
   ring_ctrl_type              ring_ctrl;
   pair_type                   head;
   pair_type                   wrap_pair;
   pair_type                   chain [MAX_FEATURES];

   // handshakes
   assign csr_ready  = (state_ff == ST_RUN) && !mac_busy;
   assign csr_accept = csr_valid && csr_ready;
   assign req_stall  = (state_ff != ST_RUN) || csr_accept;
   assign req_accept = req_valid && !req_stall;

   assign head   = chain[0];
   assign at_end = pos_ff == LEN_W'(len_ff - 1'b1);
   assign pred   = acc > 0;
   assign upd    = learn_ff && (pred != label_ff);

   // weight ring
   for (genvar k = 0; k < MAX_FEATURES; k++) begin : g_cell
      if (k == MAX_FEATURES - 1) begin : g_last
         ptrn_cell #(.INDEX(k)) u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (ring_ctrl),
            .next_pair (wrap_pair),
            .wrap_pair (wrap_pair),
            .pair      (chain[k])
         );
      end else begin : g_mid
         ptrn_cell #(.INDEX(k)) u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (ring_ctrl),
            .next_pair (chain[k+1]),
            .wrap_pair (wrap_pair),
            .pair      (chain[k])
         );
      end
   end

   ptrn_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .start   (req_accept),
      .clear   (mac_clear),
      .weight  (head.weight),
      .feature (req_feature),
      .acc     (acc),
      .busy    (mac_busy)
   );

   // row sequencer: next state, ring control, head slot
   always_comb begin
      state_in        = state_ff;
      pos_in          = pos_ff;
      len_in          = len_ff;
      mac_clear       = 1'b0;
      rsp_load        = 1'b0;
      ring_ctrl.shift = 1'b0;
      ring_ctrl.len   = LEN_MAX_W'(len_ff);
      wrap_pair       = head;
      unique case (state_ff)
         ST_RUN: begin
            wrap_pair.feature = req_feature;
            if (csr_accept) begin
               mac_clear = 1'b1;
               if (pos_ff != '0) begin
                  state_in = ST_ALIGN;
               end else begin
                  len_in = eff_len(csr_active_features);
               end
            end else if (req_accept) begin
               ring_ctrl.shift = 1'b1;
               if (at_end) begin
                  pos_in   = '0;
                  state_in = ST_SUM;
               end else begin
                  pos_in = LEN_W'(pos_ff + 1'b1);
               end
            end
         end
         ST_SUM: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load  = 1'b1;
               mac_clear = 1'b1;
               state_in  = upd ? ST_UPDATE : ST_RUN;
            end
         end
         ST_UPDATE: begin
            ring_ctrl.shift  = 1'b1;
            wrap_pair.weight = sat_update(head.weight, head.feature, label_ff);
            if (at_end) begin
               pos_in   = '0;
               state_in = ST_RUN;
            end else begin
               pos_in = LEN_W'(pos_ff + 1'b1);
            end
         end
         ST_ALIGN: begin
            ring_ctrl.shift = 1'b1;
            if (at_end) begin
               pos_in   = '0;
               len_in   = eff_len(cfg_ff);
               state_in = ST_RUN;
            end else begin
               pos_in = LEN_W'(pos_ff + 1'b1);
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
         pos_ff   <= '0;
         len_ff   <= eff_len(CFG_RESET);
         cfg_ff   <= CFG_RESET;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         len_ff   <= len_in;
         if (csr_accept) begin
            cfg_ff <= csr_active_features;
         end
      end
   end

   // row flags; the last beat of the row wins
   always_ff @(posedge clock) begin
      if (req_accept) begin
         label_ff <= req_label;
         learn_ff <= req_learn;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_pred_ff  <= pred;
         rsp_upd_ff   <= upd;
         rsp_score_ff <= acc;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_prediction = rsp_pred_ff;
   assign rsp_updated    = rsp_upd_ff;
   assign rsp_score      = rsp_score_ff;

   // position never leaves the ring
   a_pos_in_ring: assert property (@(posedge clock) disable iff (reset)
      pos_ff < len_ff)
      else $error("row position beyond ring length");

   // a result appears only from the emit step
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result raised outside emit");

   // score is final when it is emitted
   a_emit_idle_mac: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> !mac_busy)
      else $error("product still in flight at emit");

   // the ring is home after an update pass
   a_update_home: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE && state_in == ST_RUN) |=> (pos_ff == '0))
      else $error("ring misaligned after update");

endmodule

// File: tb/sv/perceptron_result_check.sv
`timescale 1ns / 1ps
// Result checker for the perceptron trainer: follows the feature, result and row length
// beats, predicts the result of every row and compares it with what the block returns.
// Depends on ptrn_pkg.
module perceptron_result_check (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  logic signed [ptrn_pkg::FEATURE_W-1:0] req_feature,
   input  logic                                  req_label,
   input  logic                                  req_learn,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic                                  rsp_prediction,
   input  logic                                  rsp_updated,
   input  logic signed [ptrn_pkg::SCORE_W-1:0]   rsp_score,
   input  logic                                  csr_valid,
   input  logic                                  csr_ready,
   input  logic [ptrn_pkg::CFG_W-1:0]            csr_active_features,
   output int                                    fail_count,
   output int                                    results_owed
);

   localparam int ROW_MAX = ptrn_pkg::DEFAULT_MAX_FEATURES;
   localparam longint SCORE_HI = (longint'(1) <<< (ptrn_pkg::SCORE_W - 1)) - 1;
   localparam longint SCORE_LO = -SCORE_HI - 1;
   localparam int WEIGHT_HI = (1 <<< (ptrn_pkg::WEIGHT_W - 1)) - 1;
   localparam int WEIGHT_LO = -WEIGHT_HI - 1;
   localparam int PRINT_CAP = 100;

   typedef struct packed {
      logic                                prediction;
      logic                                updated;
      logic signed [ptrn_pkg::SCORE_W-1:0] score;
   } row_result_t;

   // Predicted state of the block
   logic signed [ptrn_pkg::WEIGHT_W-1:0]  weight_mem [ROW_MAX];
   logic signed [ptrn_pkg::FEATURE_W-1:0] row_feats [ROW_MAX];
   longint                                dot_sum;
   int                                    feat_pos;
   logic [ptrn_pkg::CFG_W-1:0]            row_len_reg;

   row_result_t owed_results [$];
   int          errors = 0;
   int          printed = 0;

   task automatic report_error(input string msg);
      if (printed < PRINT_CAP) begin
         $display("[%0t] MISMATCH: %s", $time, msg);
         printed++;
      end
      errors++;
   endtask

   // One feature beat: buffer it, accumulate its product, close the row on the last one
   task automatic absorb_feature(input logic signed [ptrn_pkg::FEATURE_W-1:0] feat,
                                 input logic label, input logic learn);
      int          len;
      int          pos;
      int          w;
      longint      sum;
      row_result_t res;
      len = int'(row_len_reg);
      if (len == 0) len = 1;
      if (len > ROW_MAX) len = ROW_MAX;
      pos = (feat_pos >= len) ? 0 : feat_pos;
      row_feats[pos] = feat;
      sum = dot_sum + longint'(weight_mem[pos]) * longint'(feat);
      if (sum > SCORE_HI) sum = SCORE_HI;
      if (sum < SCORE_LO) sum = SCORE_LO;
      dot_sum = sum;
      if (pos + 1 < len) begin
         feat_pos = pos + 1;
      end else begin
         res.prediction = (sum > 0);
         res.updated    = learn && (res.prediction != label);
         res.score      = sum[ptrn_pkg::SCORE_W-1:0];
         // unit-step correction toward the label, weights saturate
         if (res.updated) begin
            for (int i = 0; i < len; i++) begin
               w = label ? int'(weight_mem[i]) + int'(row_feats[i])
                         : int'(weight_mem[i]) - int'(row_feats[i]);
               if (w > WEIGHT_HI) w = WEIGHT_HI;
               if (w < WEIGHT_LO) w = WEIGHT_LO;
               weight_mem[i] = w[ptrn_pkg::WEIGHT_W-1:0];
            end
         end
         owed_results.push_back(res);
         feat_pos = 0;
         dot_sum  = 0;
      end
   endtask

   always @(posedge clock) begin : watch
      row_result_t want;
      if (reset) begin
         for (int i = 0; i < ROW_MAX; i++) begin
            weight_mem[i] = '0;
            row_feats[i]  = '0;
         end
         dot_sum     = 0;
         feat_pos    = 0;
         row_len_reg = ptrn_pkg::CFG_RESET;
         owed_results.delete();
      end else begin
         // a length write drops any partial row
         if (csr_valid && csr_ready) begin
            row_len_reg = csr_active_features;
            feat_pos    = 0;
            dot_sum     = 0;
         end
         if (req_valid && !req_stall) absorb_feature(req_feature, req_label, req_learn);
         // result beat against the oldest pending row
         if (rsp_valid && !rsp_stall) begin
            if (owed_results.size() == 0) begin
               report_error($sformatf("result with no row pending, score %0d", rsp_score));
            end else begin
               want = owed_results.pop_front();
               if (rsp_prediction !== want.prediction)
                  report_error($sformatf("prediction %b, want %b",
                                         rsp_prediction, want.prediction));
               if (rsp_updated !== want.updated)
                  report_error($sformatf("updated %b, want %b", rsp_updated, want.updated));
               if (rsp_score !== want.score)
                  report_error($sformatf("score %0d, want %0d", rsp_score, want.score));
            end
         end
      end
      fail_count   <= errors;
      results_owed <= owed_results.size();
   end

endmodule

// File: tb/sv/perceptron_trainer_test.sv
`timescale 1ns / 1ps
// Top of the perceptron trainer testbench: clock, reset, feature rows and length writes,
// random idling on both channels, watchdog and verdict.
// Depends on ptrn_pkg, perceptron_trainer and perceptron_result_check.
module perceptron_trainer_test;

   localparam int RESET_CYCLES  = 6;
   localparam int SETTLE_CYCLES = 2 * ptrn_pkg::DEFAULT_MAX_FEATURES + 12;
   localparam int QUIET_LIMIT   = 4000;
   localparam int PHASE_ITEMS   = 128;
   localparam int NUM_PHASES    = 12;

   typedef enum {FEAT_FULL, FEAT_EDGE, FEAT_NEAR_ZERO} feat_mix_t;
   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  req_valid = 1'b0;
   logic                                  req_stall;
   logic signed [ptrn_pkg::FEATURE_W-1:0] req_feature = '0;
   logic                                  req_label = 1'b0;
   logic                                  req_learn = 1'b0;
   logic                                  rsp_valid;
   logic                                  rsp_stall = 1'b0;
   logic                                  rsp_prediction;
   logic                                  rsp_updated;
   logic signed [ptrn_pkg::SCORE_W-1:0]   rsp_score;
   logic                                  csr_valid = 1'b0;
   logic                                  csr_ready;
   logic [ptrn_pkg::CFG_W-1:0]            csr_active_features = '0;

   int fail_count;
   int results_owed;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int row_len = ptrn_pkg::DEFAULT_MAX_FEATURES;
   int quiet_cycles = 0;

   logic [ptrn_pkg::CFG_W-1:0] row_settings [NUM_PHASES] =
      '{7'd64, 7'd5, 7'd1, 7'd127, 7'd2, 7'd17, 7'd3, 7'd0, 7'd8, 7'd33, 7'd4, 7'd12};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   perceptron_trainer uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_feature         (req_feature),
      .req_label           (req_label),
      .req_learn           (req_learn),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_prediction      (rsp_prediction),
      .rsp_updated         (rsp_updated),
      .rsp_score           (rsp_score),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_active_features (csr_active_features)
   );

   perceptron_result_check result_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_feature         (req_feature),
      .req_label           (req_label),
      .req_learn           (req_learn),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_prediction      (rsp_prediction),
      .rsp_updated         (rsp_updated),
      .rsp_score           (rsp_score),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_active_features (csr_active_features),
      .fail_count          (fail_count),
      .results_owed        (results_owed)
   );

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Watchdog: cycles without any accepted beat
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic set_idle(input idle_mode_t mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;
            stall_pct     = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct = 62;
            stall_pct     = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct = 0;
            stall_pct     = 62;
         end
         default: begin
            send_idle_pct = 32;
            stall_pct     = 32;
         end
      endcase
   endtask

   // One feature beat, with random idle cycles ahead of it
   task automatic send_beat(input logic signed [ptrn_pkg::FEATURE_W-1:0] feat,
                            input logic label, input logic learn);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_feature <= feat;
      req_label   <= label;
      req_learn   <= learn;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Row length write once the block is quiet
   task automatic write_row_length(input logic [ptrn_pkg::CFG_W-1:0] value);
      req_valid <= 1'b0;
      do @(posedge clock); while (results_owed != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid           <= 1'b1;
      csr_active_features <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      row_len = (value == 0) ? 1 : (value > ptrn_pkg::DEFAULT_MAX_FEATURES)
                ? ptrn_pkg::DEFAULT_MAX_FEATURES : int'(value);
   endtask

   function automatic logic signed [ptrn_pkg::FEATURE_W-1:0] pick_feature(
         input feat_mix_t mix);
      logic signed [ptrn_pkg::FEATURE_W-1:0] f;
      case (mix)
         FEAT_FULL: f = $urandom;
         FEAT_EDGE: begin
            case ($urandom_range(4))
               0:       f = 16'sh7FFF;
               1:       f = 16'sh8000;
               2:       f = 16'sh0000;
               3:       f = 16'shFFFF;
               default: f = 16'sh0001;
            endcase
         end
         default: f = $urandom_range(511) - 256;
      endcase
      return f;
   endfunction

   // count features of one row; label and learn only matter on the row's last beat
   task automatic send_row(input int count);
      feat_mix_t mix;
      logic      last;
      mix = feat_mix_t'($urandom_range(2));
      for (int k = 0; k < count; k++) begin
         last = (k == row_len - 1);
         send_beat(pick_feature(mix), $urandom_range(1),
                   last ? ($urandom_range(3) != 0) : $urandom_range(1));
      end
   endtask

   initial begin : stimulus
      int phase_items;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed: single-feature rows, zero score, both labels, extremes
      set_idle(IDLE_BOTH);
      write_row_length(7'd1);
      send_beat(16'sh0000, 1'b1, 1'b1);
      send_beat(16'sh7FFF, 1'b1, 1'b1);
      send_beat(16'sh8000, 1'b1, 1'b0);
      send_beat(16'sh8000, 1'b0, 1'b1);
      send_beat(16'sh7FFF, 1'b0, 1'b1);
      send_beat(16'shFFFF, 1'b0, 1'b1);
      send_beat(16'sh0001, 1'b1, 1'b1);
      send_beat(16'sh0001, 1'b0, 1'b0);
      // partial row dropped by a length write; length zero acts as one
      write_row_length(7'd3);
      send_beat(16'sh7FFF, 1'b1, 1'b1);
      send_beat(16'sh8000, 1'b0, 1'b0);
      write_row_length(7'd0);
      send_beat(16'sh8000, 1'b0, 1'b1);
      send_beat(16'sh5555, 1'b1, 1'b1);
      write_row_length(7'd2);
      send_beat(16'sh7FFF, 1'b0, 1'b0);
      send_beat(16'sh8000, 1'b1, 1'b1);
      send_beat(16'sh8000, 1'b1, 1'b0);
      send_beat(16'sh7FFF, 1'b0, 1'b1);

      // Random: whole rows per length setting, sometimes a dropped partial row
      for (int p = 0; p < NUM_PHASES; p++) begin
         set_idle(idle_mode_t'(p % 4));
         write_row_length(row_settings[p]);
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            send_row(row_len);
            phase_items += row_len;
         end
         if (row_len > 1 && $urandom_range(2) == 0) send_row($urandom_range(row_len - 1, 1));
      end

      // Drain and verdict
      req_valid <= 1'b0;
      do @(posedge clock); while (results_owed != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
